// ===== src/mesh_area_volume_accumulator_macros.svh =====
// Assertion macros shared by the mesh area and volume accumulator.
// Each macro expects a clock named clk and a synchronous reset named rst.
`ifndef MESH_AREA_VOLUME_ACCUMULATOR_MACROS_SVH
`define MESH_AREA_VOLUME_ACCUMULATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MAVA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MAVA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mava_pkg.sv =====
// Shared types, widths and arithmetic helpers of the mesh area/volume accumulator.
// Used by the controller, the datapath, the square root unit and the top level.
`default_nettype none

package mava_pkg;

  // Coordinate precision and field widths.
  localparam int COORD_BITS = 16;
  localparam int FIELD_W    = 16;
  localparam int CFG_W      = 16;
  // Width of a vertex difference (covers coordinate minus center).
  localparam int EW   = ((COORD_BITS > CFG_W) ? COORD_BITS : CFG_W) + 1;
  localparam int XW   = 2 * EW + 1;          // cross product component
  localparam int PW   = 2 * XW;              // multiplier product
  localparam int SQW  = 2 * XW;              // squared length sum
  localparam int RW   = XW;                  // square root result
  localparam int VW   = 3 * (EW - 1) + 4;    // one triangle volume term
  localparam int AREA_W = 56;
  localparam int VOL_W  = 63;
  localparam int OUT_W  = 296;
  localparam int IN_W   = 9 * FIELD_W;

  localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

  // Configuration register indexes (paddr[3:2]).
  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;
  localparam logic [1:0] REG_CENTER_Z = 2'd2;

  // Multiply schedule: counter runs one past the last step to drain the product.
  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] CNT_LAST = 5'd21;

  typedef enum logic [CNT_W-1:0] {
    S_OX0A, S_OX0B, S_OX1A, S_OX1B, S_OX2A, S_OX2B,
    S_SQ0, S_SQ1, S_SQ2,
    S_VO0, S_VO1, S_VO2,
    S_CX0A, S_CX0B, S_CX1A, S_CX1B, S_CX2A, S_CX2B,
    S_VC0, S_VC1, S_VC2
  } step_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_SQ_START, ST_SQ_WAIT, ST_COMMIT
  } state_t;

  typedef struct packed {
    logic  load;
    logic  mul_en;
    step_t mul_step;
    logic  acc_en;
    step_t acc_step;
    logic  sq_start;
    logic  commit;
  } cmd_t;

  typedef struct packed {
    logic sq_done;
    logic mesh_end;
  } status_t;

  // Unsigned add that clamps at the all-ones area value.
  function automatic logic [AREA_W-1:0] sat_area(input logic [AREA_W-1:0] a,
                                                 input logic [AREA_W-1:0] b);
    logic [AREA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[AREA_W] ? AREA_MAX : s[AREA_W-1:0];
  endfunction

  // Signed add that clamps to the 63-bit two's complement range.
  function automatic logic signed [VOL_W-1:0] sat_vol(input logic signed [VOL_W-1:0] a,
                                                      input logic signed [VOL_W-1:0] b);
    logic signed [VOL_W:0] s;
    s = (VOL_W+1)'(a) + (VOL_W+1)'(b);
    if (s[VOL_W] != s[VOL_W-1]) begin
      return s[VOL_W] ? {1'b1, {(VOL_W-1){1'b0}}} : {1'b0, {(VOL_W-1){1'b1}}};
    end
    return s[VOL_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/mesh_area_volume_accumulator.sv =====
// Mesh area and volume accumulator.
// Triangles enter on s_axis (coordinates in tdata, mesh end on tlast, cell
// end on tuser); one result per mesh leaves on m_axis. The center point is
// set over an APB port at byte addresses 0, 4 and 8 (x, y, z).
// Each triangle passes from transfer to commit through the 21 products on the
// single shared multiplier, the square root start, the wait on the bit-serial
// square root (35 iterations and the done pulse) and the commit; the next
// triangle is taken in the cycle after commit, so a new triangle is never
// taken before the last one is through. The multiplier schedule and the
// square root iteration set the time per triangle.
// A result appears in the cycle after the commit of a triangle with tlast
// set and stays in the output register until its transfer; meanwhile the
// block goes on with the next triangles and only holds a later commit of a
// mesh result while the earlier one still waits.
// Reset (rst, synchronous) clears all sums, the center registers and the
// output valid; the block is ready in the first cycle after reset.
// Depends on mava_pkg, mava_ctrl, mava_datapath, mava_isqrt.
`default_nettype none

`include "mesh_area_volume_accumulator_macros.svh"

module mesh_area_volume_accumulator
  import mava_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // APB configuration port.
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  // Triangle input.
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: p_x, p_y, p_z, q_x, q_y, q_z, r_x, r_y, r_z (16 bits each)
  input  wire logic [IN_W-1:0]   s_axis_tdata,
  input  wire logic              s_axis_tlast,   // mesh_end
  input  wire logic              s_axis_tuser,   // cell_end
  // Result output.
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // tdata: total_area_x2 (56), min_cell_area_x2 (56), max_cell_area_x2 (56),
  //        volume_x6 (63), volume_error_x6 (63), two zero pad bits
  output logic [OUT_W-1:0]       m_axis_tdata
);

  logic signed [CFG_W-1:0] center [3];
  logic                    cfg_wr;
  cmd_t                    cmd;
  status_t                 status;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      center[0] <= '0;
      center[1] <= '0;
      center[2] <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_CENTER_X: center[0] <= pwdata[CFG_W-1:0];
        REG_CENTER_Y: center[1] <= pwdata[CFG_W-1:0];
        REG_CENTER_Z: center[2] <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (paddr[3:2])
      REG_CENTER_X: prdata = {16'h0000, center[0]};
      REG_CENTER_Y: prdata = {16'h0000, center[1]};
      REG_CENTER_Z: prdata = {16'h0000, center[2]};
      default:      prdata = '0;
    endcase
  end

  mava_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  mava_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .in_data     (s_axis_tdata),
    .in_cell_end (s_axis_tuser),
    .in_mesh_end (s_axis_tlast),
    .center      (center),
    .out_data    (m_axis_tdata)
  );

  // A triangle transfer starts the multiply schedule, so ready drops.
  `MAVA_ASSERT_NEXT(a_busy_after_in, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready after accept")
  // Every mesh closes at least one cell, so min never exceeds max.
  `MAVA_ASSERT_NOW(a_min_le_max, m_axis_tvalid, m_axis_tdata[111:56] <= m_axis_tdata[167:112], "min above max")
  // A write to the x register lands in the center register.
  `MAVA_ASSERT_NEXT(a_cfg_x, cfg_wr && (paddr[3:2] == REG_CENTER_X), center[0] == $past(pwdata[15:0]), "center x write lost")

endmodule

`default_nettype wire

// ===== src/mava_isqrt.sv =====
// Bit-serial floor square root, one result bit per cycle.
// Depends on mava_pkg for the radicand and root widths.
`default_nettype none

module mava_isqrt
  import mava_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [SQW-1:0] rad,
  output logic                done,
  output logic [RW-1:0]       root
);

  localparam int ICNT_W = $clog2(RW);

  logic [RW+1:0]   rem;
  logic [SQW-1:0]  rad_sh;
  logic [ICNT_W-1:0] cnt;
  logic            busy;
  logic [RW+3:0]   rem_sh;
  logic [RW+3:0]   trial;
  logic            fits;

  // Bring down two radicand bits and try the next root bit.
  always_comb begin
    rem_sh = {rem, rad_sh[SQW-1 -: 2]};
    trial  = {2'b00, root, 2'b01};
    fits   = (rem_sh >= trial);
  end

  // Control: busy while the root bits are formed, done pulses after the last bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == ICNT_W'(RW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder, root and radicand shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= '0;
      root   <= '0;
      rad_sh <= rad;
    end else if (busy) begin
      rem    <= fits ? (RW+2)'(rem_sh - trial) : rem_sh[RW+1:0];
      root   <= {root[RW-2:0], fits};
      rad_sh <= {rad_sh[SQW-3:0], 2'b00};
    end
  end

endmodule

`default_nettype wire

// ===== src/mava_ctrl.sv =====
// Sequencing state machine: input handshake, multiply schedule, square root
// start and commit, and the output valid flag. Depends on mava_pkg.
`default_nettype none

module mava_ctrl
  import mava_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt;
  logic             commit_ok;

  // Only a mesh end writes the result register, so only it waits for a free slot.
  assign commit_ok = !status.mesh_end || !out_valid || out_ready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_valid) state_next = ST_MUL;
      ST_MUL:      if (cnt == CNT_LAST) state_next = ST_SQ_START;
      ST_SQ_START: state_next = ST_SQ_WAIT;
      ST_SQ_WAIT:  if (status.sq_done) state_next = ST_COMMIT;
      ST_COMMIT:   if (commit_ok) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Outputs to the datapath.
  always_comb begin
    in_ready     = (state == ST_IDLE);
    cmd          = '0;
    cmd.load     = (state == ST_IDLE) && in_valid;
    cmd.mul_en   = (state == ST_MUL) && (cnt != CNT_LAST);
    cmd.mul_step = step_t'(cnt);
    cmd.acc_en   = (state == ST_MUL) && (cnt != '0);
    cmd.acc_step = step_t'(cnt - 1'b1);
    cmd.sq_start = (state == ST_SQ_START);
    cmd.commit   = (state == ST_COMMIT) && commit_ok;
  end

  // State, step counter and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= (state == ST_MUL) ? cnt + 1'b1 : '0;
      if (cmd.commit && status.mesh_end) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/mava_datapath.sv =====
// Datapath: vertex latch, shared multiplier, cross/dot accumulation, square
// root unit, running sums and the result register. Depends on mava_pkg.
`default_nettype none

module mava_datapath
  import mava_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire cmd_t                    cmd,
  output status_t                      status,
  input  wire logic [IN_W-1:0]         in_data,
  input  wire logic                    in_cell_end,
  input  wire logic                    in_mesh_end,
  input  wire logic signed [CFG_W-1:0] center [3],
  output logic [OUT_W-1:0]             out_data
);

  logic signed [COORD_BITS-1:0] p [3];
  logic signed [COORD_BITS-1:0] q [3];
  logic signed [COORD_BITS-1:0] r [3];
  logic                         cend, mend;

  logic signed [EW-1:0] a [3];
  logic signed [EW-1:0] b [3];
  logic signed [EW-1:0] u [3];
  logic signed [EW-1:0] v [3];
  logic signed [EW-1:0] w [3];

  logic signed [XW-1:0] op_a, op_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] part;
  logic signed [XW-1:0] x [3];
  logic [SQW-1:0]       sq;
  logic signed [VW-1:0] vol_o, vol_c;

  logic          sq_done;
  logic [RW-1:0] tri_root;

  logic [AREA_W-1:0]       area_sum, cell_sum, min_cell, max_cell;
  logic signed [VOL_W-1:0] vc_sum, vo_sum;
  logic [AREA_W-1:0]       cell_new, area_new, min_new, max_new;
  logic signed [VOL_W-1:0] vc_new, vo_new;
  logic signed [VOL_W:0]   vdiff;
  logic [VOL_W-1:0]        verr;

  logic [AREA_W-1:0] o_area, o_min, o_max;
  logic [VOL_W-1:0]  o_vc, o_err;

  // Latch the triangle; each coordinate takes the low COORD_BITS of its field.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < 3; k++) begin
        p[k] <= in_data[FIELD_W*k +: COORD_BITS];
        q[k] <= in_data[FIELD_W*(3+k) +: COORD_BITS];
        r[k] <= in_data[FIELD_W*(6+k) +: COORD_BITS];
      end
      cend <= in_cell_end || in_mesh_end;
      mend <= in_mesh_end;
    end
  end

  // Edge vectors and center-relative vertices.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      a[k] = EW'(q[k]) - EW'(p[k]);
      b[k] = EW'(r[k]) - EW'(p[k]);
      u[k] = EW'(p[k]) - EW'(center[k]);
      v[k] = EW'(q[k]) - EW'(center[k]);
      w[k] = EW'(r[k]) - EW'(center[k]);
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (cmd.mul_step)
      S_OX0A: begin op_a = XW'(a[1]); op_b = XW'(b[2]); end
      S_OX0B: begin op_a = XW'(a[2]); op_b = XW'(b[1]); end
      S_OX1A: begin op_a = XW'(a[2]); op_b = XW'(b[0]); end
      S_OX1B: begin op_a = XW'(a[0]); op_b = XW'(b[2]); end
      S_OX2A: begin op_a = XW'(a[0]); op_b = XW'(b[1]); end
      S_OX2B: begin op_a = XW'(a[1]); op_b = XW'(b[0]); end
      S_SQ0:  begin op_a = x[0]; op_b = x[0]; end
      S_SQ1:  begin op_a = x[1]; op_b = x[1]; end
      S_SQ2:  begin op_a = x[2]; op_b = x[2]; end
      S_VO0:  begin op_a = XW'(p[0]); op_b = x[0]; end
      S_VO1:  begin op_a = XW'(p[1]); op_b = x[1]; end
      S_VO2:  begin op_a = XW'(p[2]); op_b = x[2]; end
      S_CX0A: begin op_a = XW'(u[1]); op_b = XW'(v[2]); end
      S_CX0B: begin op_a = XW'(u[2]); op_b = XW'(v[1]); end
      S_CX1A: begin op_a = XW'(u[2]); op_b = XW'(v[0]); end
      S_CX1B: begin op_a = XW'(u[0]); op_b = XW'(v[2]); end
      S_CX2A: begin op_a = XW'(u[0]); op_b = XW'(v[1]); end
      S_CX2B: begin op_a = XW'(u[1]); op_b = XW'(v[0]); end
      S_VC0:  begin op_a = x[0]; op_b = XW'(w[0]); end
      S_VC1:  begin op_a = x[1]; op_b = XW'(w[1]); end
      S_VC2:  begin op_a = x[2]; op_b = XW'(w[2]); end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  // Registered product.
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= op_a * op_b;
    end
  end

  // Consume the product of the previous step.
  always_ff @(posedge clk) begin
    if (cmd.acc_en) begin
      unique case (cmd.acc_step)
        S_OX0A, S_OX1A, S_OX2A, S_CX0A, S_CX1A, S_CX2A: part <= prod;
        S_OX0B, S_CX0B: x[0] <= XW'(part - prod);
        S_OX1B, S_CX1B: x[1] <= XW'(part - prod);
        S_OX2B, S_CX2B: x[2] <= XW'(part - prod);
        S_SQ0:          sq <= $unsigned(prod);
        S_SQ1, S_SQ2:   sq <= sq + $unsigned(prod);
        S_VO0:          vol_o <= VW'(prod);
        S_VO1, S_VO2:   vol_o <= vol_o + VW'(prod);
        S_VC0:          vol_c <= VW'(prod);
        S_VC1, S_VC2:   vol_c <= vol_c + VW'(prod);
        default: ;
      endcase
    end
  end

  mava_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.sq_start),
    .rad   (sq),
    .done  (sq_done),
    .root  (tri_root)
  );

  assign status.sq_done  = sq_done;
  assign status.mesh_end = mend;

  // Updated sums for the triangle being committed.
  always_comb begin
    cell_new = sat_area(cell_sum, AREA_W'(tri_root));
    area_new = cend ? sat_area(area_sum, cell_new) : area_sum;
    max_new  = (cend && (cell_new > max_cell)) ? cell_new : max_cell;
    min_new  = (cend && (cell_new < min_cell)) ? cell_new : min_cell;
    vo_new   = sat_vol(vo_sum, VOL_W'(vol_o));
    vc_new   = sat_vol(vc_sum, VOL_W'(vol_c));
    vdiff    = (VOL_W+1)'(vc_new) - (VOL_W+1)'(vo_new);
    verr     = vdiff[VOL_W] ? VOL_W'(-vdiff) : vdiff[VOL_W-1:0];
  end

  // Running sums; a mesh end returns them to their reset values.
  always_ff @(posedge clk) begin
    if (rst || (cmd.commit && mend)) begin
      area_sum <= '0;
      cell_sum <= '0;
      min_cell <= AREA_MAX;
      max_cell <= '0;
      vc_sum   <= '0;
      vo_sum   <= '0;
    end else if (cmd.commit) begin
      area_sum <= area_new;
      cell_sum <= cend ? '0 : cell_new;
      min_cell <= min_new;
      max_cell <= max_new;
      vc_sum   <= vc_new;
      vo_sum   <= vo_new;
    end
  end

  // Result register, loaded when a mesh closes.
  always_ff @(posedge clk) begin
    if (cmd.commit && mend) begin
      o_area <= area_new;
      o_min  <= min_new;
      o_max  <= max_new;
      o_vc   <= vc_new;
      o_err  <= verr;
    end
  end

  assign out_data = {2'b00, o_err, o_vc, o_max, o_min, o_area};

endmodule

`default_nettype wire

// ===== verif/mesh_area_volume_accumulator_check.sv =====
// Checker for the mesh area and volume accumulator: watches the APB port and both
// streams, predicts each mesh result and compares it field by field.
// Depends on mava_pkg for the stream widths.
module mesh_area_volume_accumulator_check
  import mava_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [IN_W-1:0]   s_axis_tdata,
  input  logic              s_axis_tlast,
  input  logic              s_axis_tuser,
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [OUT_W-1:0]  m_axis_tdata,
  output int                errors,
  output int                pending,
  output int                meshes_seen
);

  localparam logic [55:0] AREA_ALL = {56{1'b1}};
  localparam longint VOL_HI = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam longint VOL_LO = -64'sh4000_0000_0000_0000;

  // Packed from the top bit down, so total_area sits in the lowest bits.
  typedef struct packed {
    logic [62:0] volume_err;
    logic [62:0] volume;
    logic [55:0] max_cell;
    logic [55:0] min_cell;
    logic [55:0] total_area;
  } mesh_totals_t;

  mesh_totals_t mesh_totals_q[$];

  // Center point and running sums of the mesh in progress.
  longint      ctr[3];
  logic [55:0] area_total, open_cell, cell_min, cell_max;
  longint      vol_center, vol_origin;

  // Floor square root of a 128-bit value, one result bit at a time.
  function automatic logic [63:0] floor_sqrt(input logic [127:0] n);
    logic [63:0]  r;
    logic [63:0]  t;
    logic [127:0] t2;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (64'd1 << b);
      t2 = {64'd0, t} * {64'd0, t};
      if (t2 <= n) r = t;
    end
    return r;
  endfunction

  function automatic logic [55:0] add_area(input logic [55:0] a, input logic [55:0] b);
    logic [56:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[56] ? AREA_ALL : s[55:0];
  endfunction

  function automatic longint add_vol(input longint a, input longint b);
    longint s;
    s = a + b;
    if (s > VOL_HI) return VOL_HI;
    if (s < VOL_LO) return VOL_LO;
    return s;
  endfunction

  function automatic logic [63:0] abs64(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  task automatic clear_sums();
    area_total = '0;
    open_cell = '0;
    cell_min = AREA_ALL;
    cell_max = '0;
    vol_center = 0;
    vol_origin = 0;
  endtask

  // Fold one triangle into the running sums; push the totals at mesh end.
  task automatic add_triangle(input logic [IN_W-1:0] d, input logic cell_end,
                              input logic mesh_end);
    longint      p[3], q[3], r[3], a[3], b[3], e[3], x[3];
    logic [127:0] len2;
    longint      vo, vc, diff;
    logic [63:0] m;
    logic [63:0] root;
    logic [63:0] diff_mag;
    mesh_totals_t res;
    for (int k = 0; k < 3; k++) begin
      p[k] = longint'($signed(d[16*k +: 16]));
      q[k] = longint'($signed(d[16*(3+k) +: 16]));
      r[k] = longint'($signed(d[16*(6+k) +: 16]));
      a[k] = q[k] - p[k];
      b[k] = r[k] - p[k];
    end
    x[0] = a[1]*b[2] - a[2]*b[1];
    x[1] = a[2]*b[0] - a[0]*b[2];
    x[2] = a[0]*b[1] - a[1]*b[0];
    len2 = '0;
    for (int k = 0; k < 3; k++) begin
      m = abs64(x[k]);
      len2 += {64'd0, m} * {64'd0, m};
    end
    vo = p[0]*x[0] + p[1]*x[1] + p[2]*x[2];
    // Volume about the center uses the vertices relative to it.
    for (int k = 0; k < 3; k++) begin
      a[k] = p[k] - ctr[k];
      b[k] = q[k] - ctr[k];
      e[k] = r[k] - ctr[k];
    end
    x[0] = a[1]*b[2] - a[2]*b[1];
    x[1] = a[2]*b[0] - a[0]*b[2];
    x[2] = a[0]*b[1] - a[1]*b[0];
    vc = x[0]*e[0] + x[1]*e[1] + x[2]*e[2];
    root = floor_sqrt(len2);
    open_cell = add_area(open_cell, root[55:0]);
    vol_origin = add_vol(vol_origin, vo);
    vol_center = add_vol(vol_center, vc);
    // A mesh end also closes the open cell.
    if (cell_end || mesh_end) begin
      area_total = add_area(area_total, open_cell);
      if (open_cell > cell_max) cell_max = open_cell;
      if (open_cell < cell_min) cell_min = open_cell;
      open_cell = '0;
    end
    if (mesh_end) begin
      diff = vol_center - vol_origin;
      diff_mag = abs64(diff);
      res.total_area = area_total;
      res.min_cell = cell_min;
      res.max_cell = cell_max;
      res.volume = vol_center[62:0];
      res.volume_err = diff_mag[62:0];
      mesh_totals_q.push_back(res);
      clear_sums();
    end
  endtask

  task automatic compare_totals(input mesh_totals_t got);
    mesh_totals_t want;
    if (mesh_totals_q.size() == 0) begin
      $display("%0t: unexpected result transfer %h", $time, got);
      errors++;
      return;
    end
    want = mesh_totals_q.pop_front();
    if (got.total_area !== want.total_area) begin
      $display("%0t: total_area_x2 expected %0d actual %0d", $time,
               want.total_area, got.total_area);
      errors++;
    end
    if (got.min_cell !== want.min_cell) begin
      $display("%0t: min_cell_area_x2 expected %0d actual %0d", $time,
               want.min_cell, got.min_cell);
      errors++;
    end
    if (got.max_cell !== want.max_cell) begin
      $display("%0t: max_cell_area_x2 expected %0d actual %0d", $time,
               want.max_cell, got.max_cell);
      errors++;
    end
    if (got.volume !== want.volume) begin
      $display("%0t: volume_x6 expected %0d actual %0d", $time,
               $signed(want.volume), $signed(got.volume));
      errors++;
    end
    if (got.volume_err !== want.volume_err) begin
      $display("%0t: volume_error_x6 expected %0d actual %0d", $time,
               want.volume_err, got.volume_err);
      errors++;
    end
  endtask

  // Monitor all three ports at the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) ctr[k] = 0;
      clear_sums();
      mesh_totals_q.delete();
      errors = 0;
      meshes_seen <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_CENTER_X: ctr[0] = longint'($signed(pwdata[15:0]));
          REG_CENTER_Y: ctr[1] = longint'($signed(pwdata[15:0]));
          REG_CENTER_Z: ctr[2] = longint'($signed(pwdata[15:0]));
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        add_triangle(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        compare_totals(m_axis_tdata[293:0]);
        meshes_seen <= meshes_seen + 1;
      end
    end
    pending <= mesh_totals_q.size();
  end

endmodule

// ===== verif/mesh_area_volume_accumulator_test.sv =====
// Testbench top of the mesh area and volume accumulator: makes clock, reset,
// APB writes and triangle stimulus. Depends on mava_pkg, the block and the checker.
module mesh_area_volume_accumulator_test;
  import mava_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;
  logic              s_axis_tlast = 1'b0;
  logic              s_axis_tuser = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;

  int errors, pending, meshes_seen;
  int tx_idle_pct = 0, rx_idle_pct = 0;
  int hold_len = 0;
  logic hold_req = 1'b0;
  int hold_left = 0;
  int triangles_sent = 0;

  mesh_area_volume_accumulator i_dut (.*);

  mesh_area_volume_accumulator_check i_check (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .errors, .pending, .meshes_seen
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side: random stalls, or a long hold-off on request.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left <= hold_len;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    #(8 * 2_000_000);
    $display("Verification failed");
    $finish;
  end

  task automatic apb_write(input logic [1:0] idx, input logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {{16{value[15]}}, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_center(input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] z);
    apb_write(REG_CENTER_X, x);
    apb_write(REG_CENTER_Y, y);
    apb_write(REG_CENTER_Z, z);
    @(posedge clk);
  endtask

  // Offer one triangle; returns at the edge of its transfer.
  task automatic send_tri(input logic [15:0] v[9], input logic cell_end,
                          input logic mesh_end);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    for (int k = 0; k < 9; k++) s_axis_tdata[16*k +: 16] <= v[k];
    s_axis_tuser <= cell_end;
    s_axis_tlast <= mesh_end;
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);
    triangles_sent++;
  endtask

  // Wait for all mesh totals, then let the block settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    // The checker's count of open results is registered, so it lags the last transfer.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_coord(input int mode);
    case (mode)
      0: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      1: return 16'($signed($urandom_range(40)) - 20);
      default: return 16'($urandom);
    endcase
  endfunction

  // Random triangle, sometimes degenerate or at the coordinate extremes.
  task automatic rand_tri(output logic [15:0] v[9]);
    int mode;
    mode = $urandom_range(9);
    for (int k = 0; k < 9; k++) v[k] = rand_coord(mode < 2 ? 0 : (mode < 4 ? 1 : 2));
    if (mode == 9) begin
      for (int k = 0; k < 3; k++) v[3+k] = v[k];
    end
  endtask

  // A well-formed mesh of random cells; its last triangle sometimes ends the mesh without a cell end.
  task automatic rand_mesh(input int max_cells);
    logic [15:0] v[9];
    int ncell, ntri;
    ncell = $urandom_range(max_cells, 1);
    for (int c = 0; c < ncell; c++) begin
      ntri = $urandom_range(4, 1);
      for (int t = 0; t < ntri; t++) begin
        rand_tri(v);
        if (c == ncell - 1 && t == ntri - 1) begin
          send_tri(v, $urandom_range(3) != 0, 1'b1);
        end else begin
          send_tri(v, t == ntri - 1, 1'b0);
        end
      end
    end
  endtask

  task automatic rand_phase(input int items);
    int start;
    start = triangles_sent;
    while (triangles_sent - start < items) rand_mesh(4);
    drain();
  endtask

  initial begin
    logic [15:0] v[9];
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, degenerate triangles and mesh end without cell end.
    for (int k = 0; k < 9; k++) v[k] = 16'h8000;
    send_tri(v, 1'b0, 1'b1);
    v = '{16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000,
          16'h8000, 16'h7FFF, 16'h8000};
    send_tri(v, 1'b1, 1'b0);
    v = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF,
          16'h7FFF, 16'h8000, 16'h8000};
    send_tri(v, 1'b0, 1'b0);
    send_tri(v, 1'b1, 1'b1);
    v = '{16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0};
    send_tri(v, 1'b1, 1'b0);
    v = '{16'd1, 16'd1, 16'd1, 16'd2, 16'd2, 16'd2, 16'd3, 16'd3, 16'd3};
    send_tri(v, 1'b1, 1'b0);
    v = '{16'hFFFF, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'hFFFF};
    send_tri(v, 1'b0, 1'b1);
    drain();

    set_center(16'h8000, 16'h8000, 16'h8000);
    v = '{16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000,
          16'h8000, 16'h8000, 16'h7FFF};
    send_tri(v, 1'b1, 1'b0);
    send_tri(v, 1'b0, 1'b1);
    for (int k = 0; k < 9; k++) v[k] = 16'h7FFF;
    send_tri(v, 1'b1, 1'b1);
    drain();

    // Random phases under changing idle patterns and center points.
    tx_idle_pct = 10;
    rx_idle_pct = 85;
    set_center(16'h7FFF, 16'h7FFF, 16'h7FFF);
    rand_phase(300);

    tx_idle_pct = 85;
    rx_idle_pct = 10;
    set_center(16'($urandom), 16'($urandom), 16'($urandom));
    rand_phase(300);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_center(16'h0000, 16'h8000, 16'h7FFF);
    rand_phase(300);

    // Long receiver hold-off while short meshes keep coming.
    hold_len = 3000;
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    for (int i = 0; i < 4; i++) rand_mesh(1);
    drain();

    set_center(16'($urandom), 16'($urandom), 16'($urandom));
    rand_phase(330);

    $display("Sent %0d triangles and checked %0d mesh results", triangles_sent,
             meshes_seen);
    $display("over six center points, three idle patterns and a long receiver hold-off.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/mava_pkg.sv
src/mava_isqrt.sv
src/mava_ctrl.sv
src/mava_datapath.sv
src/mesh_area_volume_accumulator.sv
verif/mesh_area_volume_accumulator_check.sv
verif/mesh_area_volume_accumulator_test.sv
